// ===== hw/rtl/i2cms_pkg.sv =====
// shared types and constants of the i2c master byte sequencer
// no dependencies; used by the front, back and top level files
package i2cms_pkg;

    // command kinds as they arrive on the request channel
    typedef enum logic [1:0] {
        KIND_START = 2'd0,
        KIND_WRITE = 2'd1,
        KIND_READ  = 2'd2,
        KIND_STOP  = 2'd3
    } t_kind;

    // classes that the front hands to the back
    typedef enum logic [1:0] {
        CLS_START   = 2'd0,
        CLS_RESTART = 2'd1,
        CLS_BYTE    = 2'd2,
        CLS_STOP    = 2'd3
    } t_cls;

    localparam int NUM_SLOTS = 9;
    localparam int SLOT_LAST = NUM_SLOTS - 1;
    localparam int SLOT_W    = $clog2(NUM_SLOTS);

    // queue between front and back
    localparam int QDEPTH = 2;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // apb register map
    localparam int APB_AW = 3;
    localparam int APB_DW = 32;
    localparam logic REG_LINES_INV = 1'b0;

    // classified command held in the queue
    typedef struct packed {
        t_cls                   cls;
        logic                   is_write;
        logic [NUM_SLOTS-1:0]   pattern;
        logic [NUM_SLOTS-1:0]   samples;
    } t_cmd;

endpackage

// ===== hw/rtl/i2cms_if.sv =====
// request and result channel interfaces of the i2c master byte sequencer
// plain valid/ready handshake; no package dependency
interface i2cms_cmd_if;
    logic       valid;
    logic       ready;
    logic [1:0] kind;
    logic [7:0] data_byte;
    logic       master_ack_level;
    logic [8:0] sda_samples;

    modport source (output valid, output kind, output data_byte,
                    output master_ack_level, output sda_samples, input ready);
    modport sink   (input valid, input kind, input data_byte,
                    input master_ack_level, input sda_samples, output ready);
endinterface

interface i2cms_res_if;
    logic       valid;
    logic       ready;
    logic       scl_level;
    logic       sda_level;
    logic       last;
    logic [7:0] read_data;
    logic       slave_nack;
    logic       any_nack;

    modport source (output valid, output scl_level, output sda_level, output last,
                    output read_data, output slave_nack, output any_nack, input ready);
    modport sink   (input valid, input scl_level, input sda_level, input last,
                    input read_data, input slave_nack, input any_nack, output ready);
endinterface

// ===== hw/rtl/i2cms_front.sv =====
// front part: takes requests, classifies them and queues them for the back
// depends on i2cms_pkg and i2cms_cmd_if
module i2cms_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    i2cms_cmd_if.sink        i_cmd,
    input  logic             i_pop,
    output logic             o_head_vld,
    output i2cms_pkg::t_cmd  o_head
);
    import i2cms_pkg::*;

    t_cmd              r_q [QDEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_cnt;
    logic              r_started;
    logic              w_push;
    t_cmd              w_cmd;

    assign i_cmd.ready = (r_cnt != QCNT_W'(QDEPTH));
    assign w_push      = i_cmd.valid && i_cmd.ready;
    assign o_head_vld  = (r_cnt != '0);
    assign o_head      = r_q[r_rd_ptr];

    // classify: start vs repeated start, byte commands get their sda pattern
    always_comb begin
        w_cmd          = '0;
        w_cmd.samples  = i_cmd.sda_samples;
        w_cmd.pattern  = '1;
        unique case (t_kind'(i_cmd.kind))
            KIND_START: w_cmd.cls = r_started ? CLS_RESTART : CLS_START;
            KIND_WRITE: begin
                w_cmd.cls      = CLS_BYTE;
                w_cmd.is_write = 1'b1;
                w_cmd.pattern  = {i_cmd.data_byte, 1'b1};
            end
            KIND_READ: begin
                w_cmd.cls      = CLS_BYTE;
                w_cmd.pattern  = {8'hFF, i_cmd.master_ack_level};
            end
            default: w_cmd.cls = CLS_STOP;
        endcase
    end

    // queue storage
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wr_ptr] <= w_cmd;
        end
    end

    // queue pointers and shadow bus state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr  <= '0;
            r_rd_ptr  <= '0;
            r_cnt     <= '0;
            r_started <= 1'b0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
                if (t_kind'(i_cmd.kind) == KIND_START) begin
                    r_started <= 1'b1;
                end else if (t_kind'(i_cmd.kind) == KIND_STOP) begin
                    r_started <= 1'b0;
                end
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            r_cnt <= r_cnt + QCNT_W'(w_push) - QCNT_W'(i_pop);
        end
    end

endmodule

// ===== hw/rtl/i2cms_back.sv =====
// back part: steps through the line changes of the queued command
// depends on i2cms_pkg and i2cms_res_if
module i2cms_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_lines_inv,
    input  logic             i_head_vld,
    input  i2cms_pkg::t_cmd  i_head,
    output logic             o_pop,
    i2cms_res_if.source      o_res
);
    import i2cms_pkg::*;

    logic              r_scl;
    logic              r_sda;
    logic              r_sticky;
    logic [SLOT_W-1:0] r_slot;
    logic [1:0]        r_phase;
    logic              r_out_vld;
    logic              r_out_scl;
    logic              r_out_sda;
    logic              r_out_last;
    logic [7:0]        r_out_rdata;
    logic              r_out_nack;
    logic              r_out_any;

    logic              n_scl;
    logic              n_sda;
    logic              n_sticky;
    logic              w_fire;
    logic              w_last;
    logic              w_nack;
    logic [7:0]        w_rdata;
    logic [SLOT_W-1:0] w_bit_idx;

    assign w_fire    = i_head_vld && (!r_out_vld || o_res.ready);
    assign o_pop     = w_fire && w_last;
    assign w_bit_idx = SLOT_W'(SLOT_LAST) - r_slot;

    // next line levels for the current step
    always_comb begin
        n_scl    = r_scl;
        n_sda    = r_sda;
        n_sticky = r_sticky;
        w_last   = 1'b0;
        w_nack   = 1'b0;
        w_rdata  = '0;
        unique case (i_head.cls)
            CLS_START: begin
                n_sticky = 1'b0;
                if (r_phase == 2'd0) begin
                    n_sda = 1'b0;
                end else begin
                    n_scl  = 1'b0;
                    w_last = 1'b1;
                end
            end
            CLS_RESTART: begin
                n_sticky = 1'b0;
                case (r_phase)
                    2'd0:    n_sda = 1'b1;
                    2'd1:    n_scl = 1'b1;
                    2'd2:    n_sda = 1'b0;
                    default: begin
                        n_scl  = 1'b0;
                        w_last = 1'b1;
                    end
                endcase
            end
            CLS_STOP: begin
                case (r_phase)
                    2'd0:    n_sda = 1'b0;
                    2'd1:    n_scl = 1'b1;
                    default: begin
                        n_sda  = 1'b1;
                        w_last = 1'b1;
                    end
                endcase
            end
            default: begin
                // byte: set sda, raise scl, drop scl, nine slots
                case (r_phase)
                    2'd0:    n_sda = i_head.pattern[w_bit_idx];
                    2'd1:    n_scl = 1'b1;
                    default: begin
                        n_scl = 1'b0;
                        if (r_slot == SLOT_W'(SLOT_LAST)) begin
                            w_last = 1'b1;
                            if (i_head.is_write) begin
                                w_nack   = i_head.samples[0];
                                n_sticky = r_sticky | i_head.samples[0];
                            end else begin
                                w_rdata = i_head.samples[NUM_SLOTS-1:1];
                            end
                        end
                    end
                endcase
            end
        endcase
    end

    // line state and step counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scl    <= 1'b1;
            r_sda    <= 1'b1;
            r_sticky <= 1'b0;
            r_slot   <= '0;
            r_phase  <= '0;
        end else if (w_fire) begin
            r_scl    <= n_scl;
            r_sda    <= n_sda;
            r_sticky <= n_sticky;
            if (w_last) begin
                r_slot  <= '0;
                r_phase <= '0;
            end else if (i_head.cls == CLS_BYTE && r_phase == 2'd2) begin
                r_slot  <= r_slot + 1'b1;
                r_phase <= '0;
            end else begin
                r_phase <= r_phase + 1'b1;
            end
        end
    end

    // output register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_fire) begin
            r_out_vld <= 1'b1;
        end else if (o_res.ready) begin
            r_out_vld <= 1'b0;
        end
    end

    // output register payload
    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_out_scl   <= n_scl ^ i_lines_inv;
            r_out_sda   <= n_sda ^ i_lines_inv;
            r_out_last  <= w_last;
            r_out_rdata <= w_rdata;
            r_out_nack  <= w_nack;
            r_out_any   <= n_sticky;
        end
    end

    assign o_res.valid      = r_out_vld;
    assign o_res.scl_level  = r_out_scl;
    assign o_res.sda_level  = r_out_sda;
    assign o_res.last       = r_out_last;
    assign o_res.read_data  = r_out_rdata;
    assign o_res.slave_nack = r_out_nack;
    assign o_res.any_nack   = r_out_any;

    // checks
    a_slot_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_slot <= SLOT_W'(SLOT_LAST))
        else $error("slot counter out of range");

    a_nack_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld && r_out_nack |-> r_out_any)
        else $error("slave nack not reflected in sticky nack");

    a_last_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld && !r_out_last |-> (r_out_rdata == '0) && !r_out_nack)
        else $error("read data or nack on a non-final result");

    a_start_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fire && w_last && (i_head.cls == CLS_START || i_head.cls == CLS_RESTART)
        |=> !r_scl && !r_sda)
        else $error("start did not leave both lines low");

endmodule

// ===== hw/rtl/i2c_master_byte_sequencer.sv =====
// i2c master byte sequencer top level: apb register, front queue and back sequencer
// path: a taken request is queued, then its first line change is registered in the output register from the queue head
// throughput: one line change per cycle from the back sequencer while the result channel
// does not stall it; a two-entry queue lets requests wait
// reset: synchronous active low; lines released high, queue empty, no transfer active
// depends on i2cms_pkg, i2cms_if, i2cms_front and i2cms_back
module i2c_master_byte_sequencer (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    i2cms_cmd_if.sink                   i_cmd,
    i2cms_res_if.source                 o_res,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [i2cms_pkg::APB_AW-1:0] paddr,
    input  logic [i2cms_pkg::APB_DW-1:0] pwdata,
    output logic [i2cms_pkg::APB_DW-1:0] prdata,
    output logic                        pready
);
    import i2cms_pkg::*;

    logic r_lines_inv;
    logic w_pop;
    logic w_head_vld;
    t_cmd w_head;
    logic w_sel_inv;

    assign pready    = 1'b1;
    assign w_sel_inv = (paddr[APB_AW-1] == REG_LINES_INV);

    // configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lines_inv <= 1'b0;
        end else if (psel && penable && pwrite && w_sel_inv) begin
            r_lines_inv <= pwdata[0];
        end
    end

    // register read back
    always_comb begin
        prdata = '0;
        if (w_sel_inv) begin
            prdata[0] = r_lines_inv;
        end
    end

    i2cms_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (i_cmd),
        .i_pop      (w_pop),
        .o_head_vld (w_head_vld),
        .o_head     (w_head)
    );

    i2cms_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_lines_inv (r_lines_inv),
        .i_head_vld  (w_head_vld),
        .i_head      (w_head),
        .o_pop       (w_pop),
        .o_res       (o_res)
    );

endmodule

// ===== verif/i2c_master_byte_sequencer_tb.sv =====
`timescale 1ns / 1ps
// self-checking testbench of the i2c master byte sequencer: line change prediction and checking
// depends on i2cms_pkg, i2cms_if and the i2c_master_byte_sequencer top level
module i2c_master_byte_sequencer_tb;
    import i2cms_pkg::*;

    localparam int  STALL_LIMIT  = 2000;
    localparam int  RANDOM_ITEMS = 230;
    localparam int  MAX_REPORTS  = 10;
    localparam logic [APB_AW-1:0] LINES_INV_ADDR = APB_AW'({REG_LINES_INV, 2'b00});

    // one expected scl/sda change and its flags
    typedef struct {
        logic       scl;
        logic       sda;
        logic       last;
        logic [7:0] read_data;
        logic       slave_nack;
        logic       any_nack;
    } t_line_change;

    logic i_clk;
    logic i_rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [APB_AW-1:0] paddr;
    logic [APB_DW-1:0] pwdata;
    logic [APB_DW-1:0] prdata;
    logic pready;

    i2cms_cmd_if cmd_ch ();
    i2cms_res_if res_ch ();

    i2c_master_byte_sequencer i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_ch),
        .o_res   (res_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // predicted bus state and configuration
    logic bus_open;
    logic nack_seen;
    logic scl_drv;
    logic sda_drv;
    logic lines_inv;

    t_line_change line_q[$];
    int  mismatches = 0;
    int  items_sent = 0;
    int  idle_cycles = 0;
    bit  cmd_held = 0;
    bit  tx_gaps_on = 1;
    bit  rx_stalls_on = 1;

    // clock
    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // line change predictor
    task automatic push_line_change();
        t_line_change lc;
        lc.scl        = scl_drv ^ lines_inv;
        lc.sda        = sda_drv ^ lines_inv;
        lc.last       = 1'b0;
        lc.read_data  = 8'h00;
        lc.slave_nack = 1'b0;
        lc.any_nack   = nack_seen;
        line_q.push_back(lc);
    endtask

    task automatic set_sda_level(input logic v);
        sda_drv = v;
        push_line_change();
    endtask

    task automatic set_scl_level(input logic v);
        scl_drv = v;
        push_line_change();
    endtask

    task automatic clock_one_bit(input logic v);
        set_sda_level(v);
        set_scl_level(1'b1);
        set_scl_level(1'b0);
    endtask

    task automatic predict_line_changes(input t_kind kind, input logic [7:0] data,
                                        input logic mack, input logic [8:0] samples);
        t_line_change tail;
        logic         ack;
        ack = samples[0];
        case (kind)
            KIND_START: begin
                nack_seen = 1'b0;
                if (bus_open) begin
                    set_sda_level(1'b1);
                    set_scl_level(1'b1);
                end
                set_sda_level(1'b0);
                bus_open = 1'b1;
                set_scl_level(1'b0);
            end
            KIND_WRITE: begin
                for (int i = 7; i >= 0; i--) clock_one_bit(data[i]);
                set_sda_level(1'b1);
                set_scl_level(1'b1);
                nack_seen = nack_seen | ack;
                set_scl_level(1'b0);
            end
            KIND_READ: begin
                for (int i = 0; i < 8; i++) clock_one_bit(1'b1);
                clock_one_bit(mack);
            end
            default: begin
                set_sda_level(1'b0);
                set_scl_level(1'b1);
                bus_open = 1'b0;
                set_sda_level(1'b1);
            end
        endcase
        // flags of the final change
        tail = line_q.pop_back();
        tail.last = 1'b1;
        if (kind == KIND_WRITE) tail.slave_nack = ack;
        if (kind == KIND_READ) tail.read_data = samples[8:1];
        line_q.push_back(tail);
    endtask

    // result checker
    task automatic note_mismatch(input string msg);
        mismatches++;
        if (mismatches <= MAX_REPORTS) $display("mismatch: %s", msg);
    endtask

    task automatic check_line_change();
        t_line_change want;
        t_line_change got;
        got.scl        = res_ch.scl_level;
        got.sda        = res_ch.sda_level;
        got.last       = res_ch.last;
        got.read_data  = res_ch.read_data;
        got.slave_nack = res_ch.slave_nack;
        got.any_nack   = res_ch.any_nack;
        if (line_q.size() == 0) begin
            note_mismatch($sformatf("unexpected line change scl=%0b sda=%0b last=%0b",
                                    got.scl, got.sda, got.last));
        end else begin
            want = line_q.pop_front();
            if (got.scl !== want.scl || got.sda !== want.sda || got.last !== want.last ||
                got.read_data !== want.read_data || got.slave_nack !== want.slave_nack ||
                got.any_nack !== want.any_nack) begin
                note_mismatch({
                    $sformatf("expected scl=%0b sda=%0b last=%0b rd=%02h snack=%0b anack=%0b",
                              want.scl, want.sda, want.last, want.read_data,
                              want.slave_nack, want.any_nack),
                    $sformatf(", got scl=%0b sda=%0b last=%0b rd=%02h snack=%0b anack=%0b",
                              got.scl, got.sda, got.last, got.read_data,
                              got.slave_nack, got.any_nack)});
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && res_ch.valid && res_ch.ready) check_line_change();
    end

    // watchdog on cycles without any handshake
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready) ||
                (psel && penable))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    // result receiver with random stalls
    initial begin
        int stall;
        res_ch.ready = 1'b0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            stall = rx_stalls_on ? $urandom_range(0, 4) : 0;
            if (stall != 0) begin
                res_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            res_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!res_ch.valid);
        end
    end

    // request sender
    task automatic send_request(input t_kind kind, input logic [7:0] data,
                                input logic mack, input logic [8:0] samples);
        int gap;
        gap = tx_gaps_on ? $urandom_range(0, 4) : 0;
        if (gap != 0) begin
            if (cmd_held) cmd_ch.valid <= 1'b0;
            cmd_held = 0;
            repeat (gap) @(posedge i_clk);
        end
        cmd_ch.valid            <= 1'b1;
        cmd_ch.kind             <= kind;
        cmd_ch.data_byte        <= data;
        cmd_ch.master_ack_level <= mack;
        cmd_ch.sda_samples      <= samples;
        cmd_held = 1;
        do @(posedge i_clk); while (!cmd_ch.ready);
        predict_line_changes(kind, data, mack, samples);
        items_sent++;
    endtask

    task automatic send_random_request(input t_kind kind);
        send_request(kind, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                     9'($urandom_range(0, 511)));
    endtask

    // hold off until every expected change has come
    task automatic wait_drained();
        if (cmd_held) cmd_ch.valid <= 1'b0;
        cmd_held = 0;
        while (line_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // apb write of the line inversion register while idle
    task automatic write_lines_inverted(input logic value);
        wait_drained();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= LINES_INV_ADDR;
        pwdata  <= APB_DW'(value);
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        lines_inv = value;
        @(posedge i_clk);
    endtask

    task automatic set_idling(input bit on);
        tx_gaps_on   = on;
        rx_stalls_on = on;
    endtask

    // byte and stop requests with no transfer open
    task automatic test_unopened_bus();
        send_request(KIND_WRITE, 8'h5A, 1'b0, 9'h000);
        send_request(KIND_STOP, 8'h00, 1'b0, 9'h000);
    endtask

    // start, repeated start and stop
    task automatic test_start_and_restart();
        send_request(KIND_START, 8'hFF, 1'b1, 9'h1FF);
        send_request(KIND_START, 8'h00, 1'b0, 9'h000);
        send_request(KIND_STOP, 8'hFF, 1'b1, 9'h1FF);
    endtask

    // write extremes, sticky nack and its clearing by a repeated start
    task automatic test_write_extremes();
        send_request(KIND_START, 8'h00, 1'b0, 9'h000);
        send_request(KIND_WRITE, 8'h00, 1'b0, 9'h000);
        send_request(KIND_WRITE, 8'hFF, 1'b1, 9'h1FF);
        send_request(KIND_WRITE, 8'h81, 1'b0, 9'h000);
        send_request(KIND_START, 8'h00, 1'b0, 9'h000);
        send_request(KIND_WRITE, 8'hA5, 1'b0, 9'h001);
        send_request(KIND_STOP, 8'h00, 1'b0, 9'h000);
    endtask

    // read extremes and both master ack levels
    task automatic test_read_extremes();
        send_request(KIND_START, 8'h00, 1'b0, 9'h000);
        send_request(KIND_READ, 8'h00, 1'b1, 9'h1FF);
        send_request(KIND_READ, 8'hFF, 1'b0, 9'h000);
        send_request(KIND_READ, 8'h00, 1'b0, 9'h155);
        send_request(KIND_READ, 8'h00, 1'b1, 9'h0AA);
        send_request(KIND_STOP, 8'h00, 1'b0, 9'h000);
    endtask

    // active-low line drive
    task automatic test_inverted_lines();
        write_lines_inverted(1'b1);
        send_request(KIND_START, 8'h00, 1'b0, 9'h000);
        send_request(KIND_WRITE, 8'h3C, 1'b0, 9'h1FE);
        send_request(KIND_READ, 8'h00, 1'b1, 9'h0F1);
        send_request(KIND_STOP, 8'h00, 1'b0, 9'h000);
        write_lines_inverted(1'b0);
    endtask

    // random transfers with noise, drain pauses and config phases
    task automatic test_random_traffic();
        int n_bytes;
        int next_phase;
        next_phase = items_sent + 50;
        while (items_sent < RANDOM_ITEMS) begin
            set_idling($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 99) < 80) begin
                // well-formed transfer with an optional repeated start
                send_random_request(KIND_START);
                n_bytes = $urandom_range(1, 4);
                for (int i = 0; i < n_bytes; i++)
                    send_random_request($urandom_range(0, 1) ? KIND_WRITE : KIND_READ);
                if ($urandom_range(0, 3) == 0) begin
                    send_random_request(KIND_START);
                    send_random_request($urandom_range(0, 1) ? KIND_WRITE : KIND_READ);
                end
                send_random_request(KIND_STOP);
            end else begin
                // noise: arbitrary request kinds
                n_bytes = $urandom_range(1, 3);
                for (int i = 0; i < n_bytes; i++)
                    send_random_request(t_kind'($urandom_range(0, 3)));
            end
            if (items_sent >= next_phase) begin
                next_phase = items_sent + 50;
                if ($urandom_range(0, 1)) write_lines_inverted(1'($urandom_range(0, 1)));
                else wait_drained();
            end
        end
    endtask

    // main sequence
    initial begin
        i_rst_n                 = 1'b0;
        cmd_ch.valid            = 1'b0;
        cmd_ch.kind             = KIND_START;
        cmd_ch.data_byte        = 8'h00;
        cmd_ch.master_ack_level = 1'b0;
        cmd_ch.sda_samples      = 9'h000;
        psel                    = 1'b0;
        penable                 = 1'b0;
        pwrite                  = 1'b0;
        paddr                   = '0;
        pwdata                  = '0;
        bus_open                = 1'b0;
        nack_seen               = 1'b0;
        scl_drv                 = 1'b1;
        sda_drv                 = 1'b1;
        lines_inv               = 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_unopened_bus();
        test_start_and_restart();
        test_write_extremes();
        test_read_extremes();
        test_inverted_lines();
        test_random_traffic();

        // drain and let the block settle
        wait_drained();
        repeat (40) @(posedge i_clk);
        if (line_q.size() != 0)
            note_mismatch($sformatf("%0d line changes never arrived", line_q.size()));
        if (mismatches == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

// ===== i2c_master_byte_sequencer.f =====
hw/rtl/i2cms_pkg.sv
hw/rtl/i2cms_if.sv
hw/rtl/i2cms_front.sv
hw/rtl/i2cms_back.sv
hw/rtl/i2c_master_byte_sequencer.sv
verif/i2c_master_byte_sequencer_tb.sv
